[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the median filter RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// condition holds at every clock edge out of reset
`define MF3_ASSERT_HOLDS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// consequent holds in the cycle after the antecedent
`define MF3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MF3_ASSERT_HOLDS(label, clk, rst_n, expr, msg)
`define MF3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[hw/rtl/mf3_pkg.sv]
// ----------------------------------------------------------------------------
// mf3_pkg
// Types, constants and compare helpers for the 3x3 median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int PIX_W      = 8;
  localparam int DIM_W      = 11;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT + 2);
  localparam int CFG_IDX_W  = 2;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int OCC_W      = $clog2(FIFO_DEPTH + 5);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [2:0]       pix3_t;
  typedef pix_t [8:0]       win9_t;

  // window word handed to the median stages
  typedef struct packed {
    logic  valid;
    logic  last;
    win9_t nb;
  } mf3_win_t;

  // result word
  typedef struct packed {
    logic valid;
    logic last;
    pix_t median;
  } mf3_res_t;

  typedef struct packed {
    logic last;
    pix_t median;
  } mf3_item_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (v > maxv) begin
      res = maxv;
    end else begin
      res = v;
    end
    return res;
  endfunction

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a < b) ? b : a;
  endfunction

  // [0] lowest, [1] middle, [2] highest
  function automatic pix3_t sort3(input pix_t a, input pix_t b, input pix_t c);
    pix_t  lo1;
    pix_t  hi1;
    pix_t  t;
    pix3_t res;
    lo1    = min2(a, b);
    hi1    = max2(a, b);
    t      = max2(lo1, c);
    res[0] = min2(lo1, c);
    res[1] = min2(hi1, t);
    res[2] = max2(hi1, t);
    return res;
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

endpackage

[hw/rtl/median_filter_3x3.sv]
// ----------------------------------------------------------------------------
// median_filter_3x3
// 3x3 zero-padded median filter over a raster-order 8-bit pixel stream.
// ----------------------------------------------------------------------------
//  Port group  Dir  Handshake            Word
//  in          in   in_valid / in_stall  in_req_type, in_pixel
//  out         out  out_valid / out_stall out_median_value, out_last_of_frame
//  cfg         in   cfg_wr_en            cfg_index, cfg_wdata
//
//  One word per clock while in_stall is low; the two line stores share one
//  1024 x 16 RAM, read and written once per cycle, with a bypass for width one.
//  A result passes the stage 1, window (s2) and median (s3, s4) registers
//  before it is written into the output queue; it can leave once it is queued.
//  Reset is synchronous; the line RAM has no clearing pass, entries
//  not yet written in a frame are masked to zero by row position.
//  in_stall rises when the 8-entry output queue plus the words in flight
//  would fill it; out_stall only holds the queue head.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module median_filter_3x3 (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_req_type,
  input  logic [mf3_pkg::PIX_W-1:0]        in_pixel,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mf3_pkg::PIX_W-1:0]        out_median_value,
  output logic                             out_last_of_frame,
  input  logic                             cfg_wr_en,
  input  logic [mf3_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mf3_pkg::DIM_W-1:0]        cfg_wdata
);

  localparam int COL_W = mf3_pkg::COL_W;
  localparam int ROW_W = mf3_pkg::ROW_W;
  localparam int PIX_W = mf3_pkg::PIX_W;
  localparam int OCC_W = mf3_pkg::OCC_W;

  // configuration and position
  logic [mf3_pkg::DIM_W-1:0] wcl_r;
  logic [mf3_pkg::DIM_W-1:0] hcl_r;
  logic [COL_W-1:0]          col_r;
  logic [COL_W-1:0]          col_nxt;
  logic [ROW_W-1:0]          row_r;
  logic [ROW_W-1:0]          row_nxt;
  logic [ROW_W-1:0]          row_end;
  logic [COL_W:0]            col_inc;

  logic       cfg_hit;
  logic       in_acc;
  logic       frame_done;
  logic       proc;
  logic       emit;
  logic       last;
  logic       left_en;
  mf3_pkg::pix_t pix_v;

  // stage 1: RAM read in flight
  logic          s1_valid_r;
  logic [COL_W-1:0] s1_col_r;
  logic          s1_top_en_r;
  logic          s1_mid_en_r;
  logic          s1_emit_r;
  logic          s1_last_r;
  logic          s1_left_en_r;
  logic          s1_col0_r;
  mf3_pkg::pix_t s1_pix_r;

  // line RAM: {upper, middle} per column
  logic [2*PIX_W-1:0] line_mem [mf3_pkg::MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_data_r;
  logic [2*PIX_W-1:0] fwd_data_r;
  logic               fwd_hit_r;
  logic [2*PIX_W-1:0] line_word;
  logic [2*PIX_W-1:0] wr_data;
  mf3_pkg::pix_t      upper_raw;
  mf3_pkg::pix_t      middle_raw;

  // window: newest two columns, rows top / middle / current
  mf3_pkg::pix3_t win1_r;
  mf3_pkg::pix3_t win2_r;
  mf3_pkg::pix3_t col_new;
  mf3_pkg::win9_t nb;

  mf3_pkg::mf3_win_t s2_r;
  mf3_pkg::mf3_res_t med_res;
  mf3_pkg::mf3_res_t head;
  logic [1:0]        med_busy;
  logic [mf3_pkg::FIFO_CNT_W-1:0] fifo_cnt;
  logic [OCC_W-1:0]  occ;
  logic              pop;

  // ---------------------------------------------------------------- stage 0
  assign cfg_hit    = cfg_wr_en && (cfg_index == mf3_pkg::REG_IMAGE_WIDTH ||
                                    cfg_index == mf3_pkg::REG_IMAGE_HEIGHT);
  assign in_acc     = in_valid && !in_stall;
  assign frame_done = (row_r >= ROW_W'(hcl_r));
  // past the last row any word acts as a flush tick; early flushes drop
  assign proc       = in_acc && (frame_done || in_req_type != mf3_pkg::REQ_FLUSH);
  assign pix_v      = frame_done ? '0 : in_pixel;
  assign col_inc    = (COL_W+1)'(col_r) + (COL_W+1)'(1);
  assign row_end    = ROW_W'(hcl_r) + ROW_W'(1);
  assign emit       = (row_r >= ROW_W'(2)) || (row_r == ROW_W'(1) && col_r != '0);
  assign last       = emit && row_r == row_end && col_r == '0;
  assign left_en    = (col_r == '0) ? (wcl_r >= mf3_pkg::DIM_W'(2))
                                    : (col_r >= COL_W'(2));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_hit) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (proc) begin
      if (last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_inc == (COL_W+1)'(wcl_r)) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcl_r      <= mf3_pkg::WIDTH_RESET;
      hcl_r      <= mf3_pkg::HEIGHT_RESET;
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= proc;
      fwd_hit_r  <= s1_valid_r && (s1_col_r == col_r);
      if (cfg_wr_en && cfg_index == mf3_pkg::REG_IMAGE_WIDTH) begin
        wcl_r <= mf3_pkg::clamp_dim(cfg_wdata, mf3_pkg::DIM_W'(mf3_pkg::MAX_WIDTH));
      end
      if (cfg_wr_en && cfg_index == mf3_pkg::REG_IMAGE_HEIGHT) begin
        hcl_r <= mf3_pkg::clamp_dim(cfg_wdata, mf3_pkg::DIM_W'(mf3_pkg::MAX_HEIGHT));
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_col_r     <= col_r;
    s1_top_en_r  <= (row_r >= ROW_W'(2));
    s1_mid_en_r  <= (row_r >= ROW_W'(1));
    s1_emit_r    <= emit;
    s1_last_r    <= last;
    s1_left_en_r <= left_en;
    s1_col0_r    <= (col_r == '0);
    s1_pix_r     <= pix_v;
    fwd_data_r   <= wr_data;
  end

  // ---------------------------------------------------------------- line RAM
  always_ff @(posedge clk) begin
    rd_data_r <= line_mem[col_r];
    if (s1_valid_r) begin
      line_mem[s1_col_r] <= wr_data;
    end
  end

  // ---------------------------------------------------------------- stage 1
  // bypass the write that lands on the column read in the same cycle
  assign line_word  = fwd_hit_r ? fwd_data_r : rd_data_r;
  assign upper_raw  = line_word[2*PIX_W-1:PIX_W];
  assign middle_raw = line_word[PIX_W-1:0];
  assign wr_data    = {middle_raw, s1_pix_r};

  assign col_new[0] = s1_top_en_r ? upper_raw : '0;
  assign col_new[1] = s1_mid_en_r ? middle_raw : '0;
  assign col_new[2] = s1_pix_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nb[k*3]   = s1_left_en_r ? win1_r[k] : '0;
      nb[k*3+1] = win2_r[k];
      nb[k*3+2] = s1_col0_r ? '0 : col_new[k];
    end
  end

  always_ff @(posedge clk) begin
    s2_r.last <= s1_last_r;
    s2_r.nb   <= nb;
    if (!rst_n) begin
      win1_r     <= '0;
      win2_r     <= '0;
      s2_r.valid <= 1'b0;
    end else begin
      s2_r.valid <= s1_valid_r && s1_emit_r;
      if (cfg_hit || (s1_valid_r && s1_last_r)) begin
        win1_r <= '0;
        win2_r <= '0;
      end else if (s1_valid_r) begin
        win1_r <= win2_r;
        win2_r <= col_new;
      end
    end
  end

  // ---------------------------------------------------------------- median + queue
  mf3_median9 u_median (
    .clk    (clk),
    .rst_n  (rst_n),
    .win_i  (s2_r),
    .res_o  (med_res),
    .busy_o (med_busy)
  );

  assign pop = head.valid && !out_stall;

  mf3_out_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_i   (med_res),
    .pop_i  (pop),
    .head_o (head),
    .cnt_o  (fifo_cnt)
  );

  // queued plus in-flight results; hold input once the queue could fill
  assign occ = OCC_W'(fifo_cnt) + OCC_W'(s1_valid_r && s1_emit_r) +
               OCC_W'(s2_r.valid) + OCC_W'(med_busy);
  assign in_stall = (occ >= OCC_W'(mf3_pkg::FIFO_DEPTH));

  assign out_valid         = head.valid;
  assign out_median_value  = head.median;
  assign out_last_of_frame = head.last;

  // ---------------------------------------------------------------- checks
  `MF3_ASSERT_HOLDS(a_col_in_range, clk, rst_n, (COL_W+1)'(col_r) < (COL_W+1)'(wcl_r), "column outside image width")
  `MF3_ASSERT_HOLDS(a_row_bound, clk, rst_n, row_r <= row_end, "row past flush end")
  `MF3_ASSERT_HOLDS(a_queue_room, clk, rst_n, occ <= OCC_W'(mf3_pkg::FIFO_DEPTH), "result queue overrun")
  `MF3_ASSERT_NEXT(a_frame_restart, clk, rst_n, proc && last, col_r == '0 && row_r == '0, "frame did not restart")

endmodule

[hw/rtl/mf3_median9.sv]
// ----------------------------------------------------------------------------
// mf3_median9
// Two-stage median of nine: sort rows, then reduce columns and take the
// median of the three candidates.
// ----------------------------------------------------------------------------
module mf3_median9 (
  input  logic              clk,
  input  logic              rst_n,
  input  mf3_pkg::mf3_win_t win_i,
  output mf3_pkg::mf3_res_t res_o,
  output logic [1:0]        busy_o
);

  logic          s3_valid_r;
  logic          s3_last_r;
  mf3_pkg::pix3_t s3_rows_r [3];
  mf3_pkg::pix3_t rows      [3];

  logic          s4_valid_r;
  logic          s4_last_r;
  mf3_pkg::pix3_t s4_cand_r;
  mf3_pkg::pix3_t cand;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rows[k] = mf3_pkg::sort3(win_i.nb[k*3], win_i.nb[k*3+1], win_i.nb[k*3+2]);
    end
  end

  // max of row minima, median of row medians, min of row maxima
  always_comb begin
    cand[0] = mf3_pkg::max2(mf3_pkg::max2(s3_rows_r[0][0], s3_rows_r[1][0]),
                            s3_rows_r[2][0]);
    cand[1] = mf3_pkg::med3(s3_rows_r[0][1], s3_rows_r[1][1], s3_rows_r[2][1]);
    cand[2] = mf3_pkg::min2(mf3_pkg::min2(s3_rows_r[0][2], s3_rows_r[1][2]),
                            s3_rows_r[2][2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= win_i.valid;
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_last_r <= win_i.last;
    s3_rows_r <= rows;
    s4_last_r <= s3_last_r;
    s4_cand_r <= cand;
  end

  assign res_o.valid  = s4_valid_r;
  assign res_o.last   = s4_last_r;
  assign res_o.median = mf3_pkg::med3(s4_cand_r[0], s4_cand_r[1], s4_cand_r[2]);
  assign busy_o       = 2'({1'b0, s3_valid_r} + {1'b0, s4_valid_r});

endmodule

[hw/rtl/mf3_out_fifo.sv]
// ----------------------------------------------------------------------------
// mf3_out_fifo
// Small result queue that decouples the filter pipeline from out_stall.
// ----------------------------------------------------------------------------
module mf3_out_fifo (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mf3_pkg::mf3_res_t                 wr_i,
  input  logic                              pop_i,
  output mf3_pkg::mf3_res_t                 head_o,
  output logic [mf3_pkg::FIFO_CNT_W-1:0]    cnt_o
);

  localparam logic [mf3_pkg::FIFO_PTR_W-1:0] PTR_LAST =
    mf3_pkg::FIFO_PTR_W'(mf3_pkg::FIFO_DEPTH - 1);

  mf3_pkg::mf3_item_t                 data_r [mf3_pkg::FIFO_DEPTH];
  logic [mf3_pkg::FIFO_PTR_W-1:0]     wr_ptr_r;
  logic [mf3_pkg::FIFO_PTR_W-1:0]     rd_ptr_r;
  logic [mf3_pkg::FIFO_CNT_W-1:0]     cnt_r;
  logic [mf3_pkg::FIFO_CNT_W-1:0]     cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_i.valid && !pop_i) begin
      cnt_nxt = cnt_r + mf3_pkg::FIFO_CNT_W'(1);
    end else if (!wr_i.valid && pop_i) begin
      cnt_nxt = cnt_r - mf3_pkg::FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr_i.valid) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + mf3_pkg::FIFO_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + mf3_pkg::FIFO_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_i.valid) begin
      data_r[wr_ptr_r] <= '{last: wr_i.last, median: wr_i.median};
    end
  end

  assign head_o.valid  = (cnt_r != '0);
  assign head_o.last   = data_r[rd_ptr_r].last;
  assign head_o.median = data_r[rd_ptr_r].median;
  assign cnt_o         = cnt_r;

endmodule
